@@ src/lhb_pkg.sv @@
`default_nettype none

package lhb_pkg;

	// Fixed field widths of the ports.
	localparam int LAT_W       = 32;
	localparam int BIN_SIZE_W  = 16;
	localparam int PERIOD_W    = 16;
	localparam int COUNT_W     = 16;
	localparam int SUM_W       = 48;
	localparam int BIN_NUM_W   = 6;
	localparam int BIN_START_W = 22;
	localparam int BAR_W       = 7;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	// Full-scale bar length of the largest bin.
	localparam int BAR_SCALE = 71;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LATENCY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 2'd2;

	// Configuration reset values.
	localparam logic [BIN_SIZE_W-1:0] RST_BIN_SIZE    = 16'd250;
	localparam logic [LAT_W-1:0]      RST_MAX_LATENCY = 32'd20000;
	localparam logic [PERIOD_W-1:0]   RST_PERIOD      = 16'd1000;

	// Shared divider: 32-bit dividend, 16-bit divisor, one quotient bit per cycle.
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = 6;

	// Micro-operations.
	localparam logic [3:0] OP_NOP       = 4'd0;
	localparam logic [3:0] OP_ACCEPT    = 4'd1;
	localparam logic [3:0] OP_DIV_MAXL  = 4'd2;
	localparam logic [3:0] OP_SET_NB    = 4'd3;
	localparam logic [3:0] OP_DIV_LAT   = 4'd4;
	localparam logic [3:0] OP_SET_BIN   = 4'd5;
	localparam logic [3:0] OP_RD_BIN    = 4'd6;
	localparam logic [3:0] OP_UPDATE    = 4'd7;
	localparam logic [3:0] OP_DIV_MIN   = 4'd8;
	localparam logic [3:0] OP_SET_FIRST = 4'd9;
	localparam logic [3:0] OP_DIV_MAX   = 4'd10;
	localparam logic [3:0] OP_SET_LASTB = 4'd11;
	localparam logic [3:0] OP_RD_IDX    = 4'd12;
	localparam logic [3:0] OP_DIV_BAR   = 4'd13;
	localparam logic [3:0] OP_EMIT      = 4'd14;
	localparam logic [3:0] OP_ADVANCE   = 4'd15;

	// Sequencer conditions. The hold conditions jump to the step itself.
	localparam logic [2:0] C_NEXT      = 3'd0;
	localparam logic [2:0] C_NO_IN     = 3'd1;
	localparam logic [2:0] C_DIV_BUSY  = 3'd2;
	localparam logic [2:0] C_OUT_BLOCK = 3'd3;
	localparam logic [2:0] C_NO_DUMP   = 3'd4;
	localparam logic [2:0] C_MORE      = 3'd5;

	localparam int PC_W = 4;

	typedef struct packed {
		logic [3:0]      op;
		logic [2:0]      cond;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	// Control store.
	function automatic ctrl_word_t ucode_fetch(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		unique case (pc)
			4'd0:  w = '{OP_ACCEPT,    C_NO_IN,     4'd0};
			4'd1:  w = '{OP_DIV_MAXL,  C_NEXT,      4'd0};
			4'd2:  w = '{OP_SET_NB,    C_DIV_BUSY,  4'd2};
			4'd3:  w = '{OP_DIV_LAT,   C_NEXT,      4'd0};
			4'd4:  w = '{OP_SET_BIN,   C_DIV_BUSY,  4'd4};
			4'd5:  w = '{OP_RD_BIN,    C_NEXT,      4'd0};
			4'd6:  w = '{OP_UPDATE,    C_NEXT,      4'd0};
			4'd7:  w = '{OP_NOP,       C_NO_DUMP,   4'd0};
			4'd8:  w = '{OP_DIV_MIN,   C_NEXT,      4'd0};
			4'd9:  w = '{OP_SET_FIRST, C_DIV_BUSY,  4'd9};
			4'd10: w = '{OP_DIV_MAX,   C_NEXT,      4'd0};
			4'd11: w = '{OP_SET_LASTB, C_DIV_BUSY,  4'd11};
			4'd12: w = '{OP_RD_IDX,    C_NEXT,      4'd0};
			4'd13: w = '{OP_DIV_BAR,   C_NEXT,      4'd0};
			4'd14: w = '{OP_EMIT,      C_OUT_BLOCK, 4'd14};
			4'd15: w = '{OP_ADVANCE,   C_MORE,      4'd12};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

@@ src/latency_histogram_binner_core.sv @@
`default_nettype none

// Latency histogram with an outlier bin.
// Configuration: a write on cfg_valid/cfg_ready with cfg_index and cfg_data sets bin_size (0),
// max_latency (1) or period_samples (2). cfg_ready is always high; write only while idle.
// Input: one latency word per in_valid/in_ready handshake. in_ready is high only while the
// sequencer waits at its first step, so the block works on one sample at a time.
// A sample takes two passes of the shared radix-2 divider, which find the bins in use and
// the sample's bin; then the bin memory is read and updated.
// When the period is complete the block dumps one output word per bin from the minimum's bin
// to the maximum's bin: the divider first locates both end bins, then computes each bin's
// rounded-up bar length.
// Output: one word per out_valid/out_ready handshake from an output register, so the
// sequencer prepares the next bin while the current word waits. If the receiver stalls, the
// sequencer holds at its emit step; the final word of a dump carries last, and the
// statistics are cleared in the step after that word is loaded into the output register,
// so the next sample can be taken while the word still waits.
// Reset: configuration returns to 250 / 20000 / 1000, all statistics clear, and the bin
// valid flags clear at once, so no clearing pass is needed; an entry without its valid flag
// reads as zero. The same flags give the per-period clear at once.
module latency_histogram_binner_core
	import lhb_pkg::*;
#(
	parameter int NUM_BINS = 64
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire  [CFG_IDX_W-1:0]   cfg_index,
	input  wire  [CFG_DATA_W-1:0]  cfg_data,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire  [LAT_W-1:0]       latency,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [BIN_NUM_W-1:0]   bin_number,
	output logic [BIN_START_W-1:0] bin_start,
	output logic                   is_outlier,
	output logic [COUNT_W-1:0]     bin_count,
	output logic [BAR_W-1:0]       bar_length,
	output logic [PERIOD_W-1:0]    sample_total,
	output logic [LAT_W-1:0]       lowest_latency,
	output logic [LAT_W-1:0]       highest_latency,
	output logic [SUM_W-1:0]       latency_total,
	output logic                   last
);

	localparam int BIN_W = (NUM_BINS > 2) ? $clog2(NUM_BINS) : 1;
	localparam logic [BIN_W-1:0] TOP_BIN = BIN_W'(NUM_BINS - 1);
	localparam logic [LAT_W-1:0] NB_SAT = LAT_W'(NUM_BINS - 2);
	localparam int BAR_NUM_W = 24;

	// Configuration registers.
	logic [BIN_SIZE_W-1:0] bin_size_q;
	logic [LAT_W-1:0]      max_lat_q;
	logic [PERIOD_W-1:0]   period_q;

	// Sequencer.
	logic [PC_W-1:0] pc_q;
	ctrl_word_t      ucw;
	logic            hold;
	logic            jump;
	logic            fire;

	// Datapath registers.
	logic [LAT_W-1:0]  lat_q;
	logic [BIN_W-1:0]  nbm1_q;
	logic [BIN_W-1:0]  bin_q;
	logic [BIN_W-1:0]  idx_q;
	logic [BIN_W-1:0]  lastb_q;
	logic [COUNT_W-1:0] cnt_q;

	// Bin memory with registered read and per-entry valid flags.
	logic [COUNT_W-1:0]  bin_mem [NUM_BINS];
	logic [NUM_BINS-1:0] vld_q;
	logic [BIN_W-1:0]    rd_addr;
	logic [COUNT_W-1:0]  rd_q;
	logic                rdv_q;
	logic [COUNT_W-1:0]  cur_cnt;
	logic [COUNT_W-1:0]  cnt_new;
	logic                mem_we;

	// Period statistics.
	logic [PERIOD_W-1:0] sample_cnt_q;
	logic [SUM_W-1:0]    sum_q;
	logic [LAT_W-1:0]    min_q;
	logic [LAT_W-1:0]    max_q;
	logic [COUNT_W-1:0]  largest_q;

	// Shared restoring divider.
	logic [BIN_SIZE_W-1:0] div_rem_q;
	logic [LAT_W-1:0]      div_dq_q;
	logic [BIN_SIZE_W-1:0] div_dsr_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic                  div_busy;
	logic                  div_start;
	logic [LAT_W-1:0]      div_dividend;
	logic [BIN_SIZE_W-1:0] div_divisor;
	logic [BIN_SIZE_W:0]   rem_sh;
	logic                  div_ge;
	logic [BIN_W-1:0]      q_clamp;
	logic [BAR_NUM_W-1:0]  bar_num;

	// Output register.
	logic                   out_valid_q;
	logic [BIN_NUM_W-1:0]   out_bin_q;
	logic [BIN_START_W-1:0] out_start_q;
	logic                   out_outlier_q;
	logic [COUNT_W-1:0]     out_count_q;
	logic [BAR_W-1:0]       out_bar_q;
	logic [PERIOD_W-1:0]    out_total_q;
	logic [LAT_W-1:0]       out_min_q;
	logic [LAT_W-1:0]       out_max_q;
	logic [SUM_W-1:0]       out_sum_q;
	logic                   out_last_q;

	assign ucw = ucode_fetch(pc_q);
	assign div_busy = (div_cnt_q != '0);

	// A hold condition keeps the step and suppresses its action.
	always_comb begin
		hold = 1'b0;
		jump = 1'b0;
		unique case (ucw.cond)
			C_NEXT:      jump = 1'b0;
			C_NO_IN:     hold = !in_valid;
			C_DIV_BUSY:  hold = div_busy;
			C_OUT_BLOCK: hold = div_busy || (out_valid_q && !out_ready);
			C_NO_DUMP:   jump = (sample_cnt_q < period_q);
			C_MORE:      jump = (idx_q != lastb_q);
			default:     jump = 1'b0;
		endcase
		jump = jump || hold;
		fire = !hold;
	end

	assign in_ready  = (ucw.op == OP_ACCEPT);
	assign cfg_ready = 1'b1;

	// Bin number of the divider's quotient, clamped to the last bin in use.
	assign q_clamp = (div_dq_q > LAT_W'(nbm1_q)) ? nbm1_q : div_dq_q[BIN_W-1:0];

	assign cur_cnt = rdv_q ? rd_q : '0;
	assign cnt_new = (cur_cnt == '1) ? cur_cnt : cur_cnt + COUNT_W'(1);
	assign bar_num = BAR_NUM_W'(cur_cnt) * BAR_NUM_W'(BAR_SCALE)
		+ BAR_NUM_W'(largest_q) - BAR_NUM_W'(1);

	assign rd_addr = (ucw.op == OP_RD_IDX) ? idx_q : bin_q;
	assign mem_we  = (ucw.op == OP_UPDATE);

	// Divider operand selection.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = lat_q;
		div_divisor  = bin_size_q;
		unique case (ucw.op)
			OP_DIV_MAXL: begin
				div_start    = 1'b1;
				div_dividend = max_lat_q;
			end
			OP_DIV_LAT: begin
				div_start = 1'b1;
			end
			OP_DIV_MIN: begin
				div_start    = 1'b1;
				div_dividend = min_q;
			end
			OP_DIV_MAX: begin
				div_start    = 1'b1;
				div_dividend = max_q;
			end
			OP_DIV_BAR: begin
				div_start    = 1'b1;
				div_dividend = LAT_W'(bar_num);
				div_divisor  = largest_q;
			end
			default: div_start = 1'b0;
		endcase
	end

	// One quotient bit per cycle. A zero divisor yields an all-ones quotient.
	assign rem_sh = {div_rem_q, div_dq_q[LAT_W-1]};
	assign div_ge = (rem_sh >= {1'b0, div_dsr_q});

	always_ff @(posedge clk) begin
		if (div_start) begin
			div_dq_q  <= div_dividend;
			div_dsr_q <= div_divisor;
			div_rem_q <= '0;
		end else if (div_busy) begin
			div_dq_q  <= {div_dq_q[LAT_W-2:0], div_ge};
			div_rem_q <= div_ge ? BIN_SIZE_W'(rem_sh - {1'b0, div_dsr_q})
				: rem_sh[BIN_SIZE_W-1:0];
		end
	end

	// Bin memory.
	always_ff @(posedge clk) begin
		rd_q  <= bin_mem[rd_addr];
		rdv_q <= vld_q[rd_addr];
		if (mem_we) begin
			bin_mem[bin_q] <= cnt_new;
		end
	end

	// Payload registers of the datapath.
	always_ff @(posedge clk) begin
		if (fire) begin
			unique case (ucw.op)
				OP_ACCEPT: begin
					lat_q <= latency;
				end
				OP_SET_NB: begin
					nbm1_q <= (div_dq_q >= NB_SAT) ? TOP_BIN
						: div_dq_q[BIN_W-1:0] + BIN_W'(1);
				end
				OP_SET_BIN: begin
					bin_q <= q_clamp;
				end
				OP_SET_FIRST: begin
					idx_q <= q_clamp;
				end
				OP_SET_LASTB: begin
					lastb_q <= q_clamp;
				end
				OP_DIV_BAR: begin
					cnt_q <= cur_cnt;
				end
				OP_ADVANCE: begin
					if (idx_q != lastb_q) begin
						idx_q <= idx_q + BIN_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Output payload, loaded at the emit step once the divider is done and the output register is free.
	always_ff @(posedge clk) begin
		if (fire && ucw.op == OP_EMIT) begin
			out_bin_q     <= BIN_NUM_W'(idx_q);
			out_start_q   <= BIN_START_W'(idx_q) * BIN_START_W'(bin_size_q);
			out_outlier_q <= (idx_q == nbm1_q);
			out_count_q   <= cnt_q;
			out_bar_q     <= (largest_q == '0) ? '0 : div_dq_q[BAR_W-1:0];
			out_total_q   <= sample_cnt_q;
			out_min_q     <= min_q;
			out_max_q     <= max_q;
			out_sum_q     <= sum_q;
			out_last_q    <= (idx_q == lastb_q);
		end
	end

	// Control state, configuration and period statistics.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q         <= '0;
			div_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
			bin_size_q   <= RST_BIN_SIZE;
			max_lat_q    <= RST_MAX_LATENCY;
			period_q     <= RST_PERIOD;
			vld_q        <= '0;
			sample_cnt_q <= '0;
			sum_q        <= '0;
			min_q        <= '1;
			max_q        <= '0;
			largest_q    <= '0;
		end else begin
			pc_q <= jump ? ucw.target : pc_q + PC_W'(1);

			if (div_start) begin
				div_cnt_q <= DIV_CNT_W'(DIV_STEPS);
			end else if (div_busy) begin
				div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			end

			if (fire && ucw.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_BIN_SIZE:    bin_size_q <= cfg_data[BIN_SIZE_W-1:0];
					CFG_MAX_LATENCY: max_lat_q  <= cfg_data[LAT_W-1:0];
					CFG_PERIOD:      period_q   <= cfg_data[PERIOD_W-1:0];
					default: begin
					end
				endcase
			end

			if (fire && ucw.op == OP_UPDATE) begin
				vld_q[bin_q] <= 1'b1;
				if (largest_q < cnt_new) begin
					largest_q <= cnt_new;
				end
				sample_cnt_q <= sample_cnt_q + PERIOD_W'(1);
				sum_q        <= sum_q + SUM_W'(lat_q);
				if (min_q > lat_q) begin
					min_q <= lat_q;
				end
				if (max_q < lat_q) begin
					max_q <= lat_q;
				end
			end

			// The final bin of a dump clears the period.
			if (fire && ucw.op == OP_ADVANCE && idx_q == lastb_q) begin
				vld_q        <= '0;
				sample_cnt_q <= '0;
				sum_q        <= '0;
				min_q        <= '1;
				max_q        <= '0;
				largest_q    <= '0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign bin_number      = out_bin_q;
	assign bin_start       = out_start_q;
	assign is_outlier      = out_outlier_q;
	assign bin_count       = out_count_q;
	assign bar_length      = out_bar_q;
	assign sample_total    = out_total_q;
	assign lowest_latency  = out_min_q;
	assign highest_latency = out_max_q;
	assign latency_total   = out_sum_q;
	assign last            = out_last_q;

endmodule

`default_nettype wire

@@ src/lhb_checker.sv @@
`default_nettype none

module lhb_checker
	import lhb_pkg::*;
(
	input wire                   clk,
	input wire                   arst_n,
	input wire                   in_valid,
	input wire                   in_ready,
	input wire                   out_valid,
	input wire                   out_ready,
	input wire [BIN_NUM_W-1:0]   bin_number,
	input wire [COUNT_W-1:0]     bin_count,
	input wire [BAR_W-1:0]       bar_length,
	input wire [PERIOD_W-1:0]    sample_total,
	input wire [LAT_W-1:0]       lowest_latency,
	input wire [LAT_W-1:0]       highest_latency,
	input wire                   last
);

	// A stalled output word keeps its content.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bin_number) && $stable(bin_count)
			&& $stable(bar_length) && $stable(last))
		else $error("output word changed while stalled");

	// Bars are scaled against the largest bin, so they never pass full scale.
	a_bar_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bar_length <= BAR_W'(BAR_SCALE))
		else $error("bar length beyond full scale");

	// An empty bin draws no bar and a filled bin always draws one.
	a_bar_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((bin_count == '0) == (bar_length == '0)))
		else $error("bar length disagrees with bin count");

	// A dump always covers at least one sample.
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> lowest_latency <= highest_latency && sample_total != '0)
		else $error("period statistics inconsistent");

	// While idle, the block keeps waiting for a sample.
	a_idle_wait: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid |=> in_ready)
		else $error("input side left idle without a sample");

endmodule

bind latency_histogram_binner_core lhb_checker u_lhb_checker (.*);

`default_nettype wire
